/* src/tcdr_pkg.sv */
package tcdr_pkg;

  // Field widths of the cell and dot words
  localparam int CELL_IDX_W = 9;
  localparam int WORD_W     = 16;
  localparam int COL_W      = 2;
  localparam int ROW_W      = 3;
  localparam int CHAN_W     = 8;
  localparam int NIB_W      = 4;
  localparam int RGB_W      = 3 * NIB_W;

  // Screen and glyph geometry
  localparam int NUM_CELLS        = 384;
  localparam int DOTS_PER_COLUMN  = 8;
  localparam int COLUMNS_PER_CELL = 4;
  localparam int GLYPH_W          = 2 * WORD_W;
  localparam int MAP_AW           = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;

  // Bit positions in the video word
  localparam int BLINK_BIT = 7;

  // Depth of the job queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Classified cell: everything the back end needs to paint 32 dots
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;   // {glyph_first, glyph_second}
    logic [RGB_W-1:0]   fg_rgb;
    logic [RGB_W-1:0]   bg_rgb;
    logic               show_fg;
  } job_t;

  function automatic logic [CHAN_W-1:0] expand_nibble(input logic [NIB_W-1:0] n);
    return {n, n};
  endfunction

endpackage

/* src/tcdr_if.sv */
interface tcdr_cell_if;
  import tcdr_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CELL_IDX_W-1:0] cell_index;
  logic [WORD_W-1:0]     cell_word;
  logic [WORD_W-1:0]     glyph_first;
  logic [WORD_W-1:0]     glyph_second;
  logic [WORD_W-1:0]     fg_palette_word;
  logic [WORD_W-1:0]     bg_palette_word;
  logic                  blink_phase;

  modport source (
    output valid, cell_index, cell_word, glyph_first, glyph_second,
           fg_palette_word, bg_palette_word, blink_phase,
    input  ready
  );
  modport sink (
    input  valid, cell_index, cell_word, glyph_first, glyph_second,
           fg_palette_word, bg_palette_word, blink_phase,
    output ready
  );
endinterface

interface tcdr_dot_if;
  import tcdr_pkg::*;

  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  dot_column;
  logic [ROW_W-1:0]  dot_row;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;
  logic              lit;
  logic              last_dot;

  modport source (
    output valid, dot_column, dot_row, red, green, blue, lit, last_dot,
    input  ready
  );
  modport sink (
    input  valid, dot_column, dot_row, red, green, blue, lit, last_dot,
    output ready
  );
endinterface

/* src/tcdr_front.sv */
module tcdr_front (
  input  logic          clk,
  input  logic          rst,
  tcdr_cell_if.sink     cells,
  output tcdr_pkg::job_t job,
  output logic          job_valid,
  input  logic          job_ready
);
  import tcdr_pkg::*;

  logic              blink_map [NUM_CELLS];
  logic              clearing;
  logic [MAP_AW-1:0] clr_cnt;

  logic              s1_valid;
  logic [MAP_AW-1:0] s1_addr;
  logic              s1_in_range;
  logic              s1_blink_bit;
  logic              s1_fwd;
  logic              s1_phase;
  logic              map_bit;
  logic [GLYPH_W-1:0] s1_glyph;
  logic [RGB_W-1:0]  s1_fg;
  logic [RGB_W-1:0]  s1_bg;

  logic              accept;
  logic              advance;
  logic              in_range;
  logic [MAP_AW-1:0] rd_addr;
  logic              s1_set;
  logic              blinking;

  assign in_range    = 32'(cells.cell_index) < 32'(NUM_CELLS);
  assign rd_addr     = in_range ? MAP_AW'(cells.cell_index) : '0;
  assign advance     = s1_valid & job_ready;
  assign cells.ready = ~clearing & (~s1_valid | job_ready);
  assign accept      = cells.valid & cells.ready;
  assign s1_set      = s1_in_range & s1_blink_bit;

  // A write leaving this cycle to the same cell is not yet in the map read
  assign blinking  = s1_in_range & (s1_blink_bit | map_bit | s1_fwd);
  assign job_valid = s1_valid;
  assign job       = '{glyph: s1_glyph, fg_rgb: s1_fg, bg_rgb: s1_bg,
                       show_fg: ~blinking | s1_phase};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else begin
      if (clearing) begin
        clr_cnt <= clr_cnt + 1'b1;
        if (clr_cnt == MAP_AW'(NUM_CELLS - 1)) begin
          clearing <= 1'b0;
        end
      end
      s1_valid <= accept | (s1_valid & ~advance);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_addr      <= rd_addr;
      s1_in_range  <= in_range;
      s1_blink_bit <= cells.cell_word[BLINK_BIT];
      s1_fwd       <= advance & s1_set & (s1_addr == rd_addr);
      s1_phase     <= cells.blink_phase;
      s1_glyph     <= {cells.glyph_first, cells.glyph_second};
      s1_fg        <= cells.fg_palette_word[RGB_W-1:0];
      s1_bg        <= cells.bg_palette_word[RGB_W-1:0];
    end
  end

  // Blink map: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (accept) begin
      map_bit <= blink_map[rd_addr];
    end
    if (clearing) begin
      blink_map[clr_cnt] <= 1'b0;
    end else if (advance && s1_set) begin
      blink_map[s1_addr] <= 1'b1;
    end
  end

endmodule

/* src/tcdr_queue.sv */
module tcdr_queue (
  input  logic           clk,
  input  logic           rst,
  input  tcdr_pkg::job_t push_job,
  input  logic           push_valid,
  output logic           push_ready,
  output tcdr_pkg::job_t pop_job,
  output logic           pop_valid,
  input  logic           pop_ready
);
  import tcdr_pkg::*;

  job_t            entries [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_CW-1:0] count;
  logic            push;
  logic            pop;

  assign push_ready = count != Q_CW'(Q_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid & push_ready;
  assign pop        = pop_valid & pop_ready;
  assign pop_job    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == Q_AW'(Q_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

endmodule

/* src/tcdr_back.sv */
module tcdr_back (
  input  logic           clk,
  input  logic           rst,
  input  tcdr_pkg::job_t job,
  input  logic           job_valid,
  output logic           job_pop,
  tcdr_dot_if.source     dots
);
  import tcdr_pkg::*;

  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic              load;
  logic              step;
  logic              last;
  logic [7:0]        column_byte;
  logic              glyph_bit;
  logic              lit_now;
  logic [RGB_W-1:0]  color;

  assign load    = ~dots.valid | dots.ready;
  assign step    = load & job_valid;
  assign last    = (col == COL_W'(COLUMNS_PER_CELL - 1)) &&
                   (row == ROW_W'(DOTS_PER_COLUMN - 1));
  assign job_pop = step & last;

  always_comb begin
    case (col)
      2'd0:    column_byte = job.glyph[31:24];
      2'd1:    column_byte = job.glyph[23:16];
      2'd2:    column_byte = job.glyph[15:8];
      default: column_byte = job.glyph[7:0];
    endcase
    glyph_bit = column_byte[row];
    lit_now   = glyph_bit & job.show_fg;
    color     = lit_now ? job.fg_rgb : job.bg_rgb;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dots.valid <= 1'b0;
      col        <= '0;
      row        <= '0;
    end else begin
      if (load) begin
        dots.valid <= job_valid;
      end
      if (step) begin
        if (row == ROW_W'(DOTS_PER_COLUMN - 1)) begin
          row <= '0;
          col <= last ? '0 : col + 1'b1;
        end else begin
          row <= row + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      dots.dot_column <= col;
      dots.dot_row    <= row;
      dots.red        <= expand_nibble(color[11:8]);
      dots.green      <= expand_nibble(color[7:4]);
      dots.blue       <= expand_nibble(color[3:0]);
      dots.lit        <= lit_now;
      dots.last_dot   <= last;
    end
  end

endmodule

/* src/text_cell_dot_renderer_unit.sv */
// Channel | Role   | Word
// --------+--------+------------------------------------------------------
// cells   | sink   | one text cell: index, video word, glyph and palette
// dots    | source | one dot: column, row, RGB888, lit, last_dot
//
// Each cell yields 32 dots; the dot stage emits one dot per cycle while dots is
// not stalled, so a cell occupies the dot stage for all of its 32 dots.
// With an empty queue the first dot of a cell passes the front register, a queue
// entry and the dot register before it is presented.
// After rst a clearing pass zeroes all NUM_CELLS (384) entries of the blink map;
// cells.ready stays low during it.
// A stall on dots holds the dot register; cells keep entering until the
// two-entry queue and the front register are full.
module text_cell_dot_renderer_unit (
  input  logic        clk,
  input  logic        rst,
  tcdr_cell_if.sink   cells,
  tcdr_dot_if.source  dots
);
  import tcdr_pkg::*;

  job_t front_job;
  logic front_valid;
  logic front_ready;
  job_t back_job;
  logic back_valid;
  logic back_pop;

  tcdr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cells     (cells),
    .job       (front_job),
    .job_valid (front_valid),
    .job_ready (front_ready)
  );

  tcdr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_job   (front_job),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_job    (back_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_pop)
  );

  tcdr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (back_job),
    .job_valid (back_valid),
    .job_pop   (back_pop),
    .dots      (dots)
  );

`ifndef ASSERT_OFF
  // Within a cell the next dot is always ready right behind the taken one
  a_dots_contiguous: assert property (@(posedge clk) disable iff (rst)
    dots.valid && dots.ready && !dots.last_dot |=> dots.valid)
    else $error("gap inside a cell's dot burst");

  a_last_dot_place: assert property (@(posedge clk) disable iff (rst)
    dots.valid && dots.last_dot |->
      dots.dot_column == COL_W'(COLUMNS_PER_CELL - 1) &&
      dots.dot_row == ROW_W'(DOTS_PER_COLUMN - 1))
    else $error("last_dot on wrong dot position");

  // Release a queue entry only together with the final dot of its cell
  a_pop_only_on_last: assert property (@(posedge clk) disable iff (rst)
    back_pop |=> dots.valid && dots.last_dot)
    else $error("queue entry released before its final dot");
`endif

endmodule
